[rtl/ahtu_pkg.sv]
package ahtu_pkg;

    localparam int MV_W      = 11;
    localparam int SUM_W     = 19;
    localparam int AVG_W     = 11;
    localparam int SP_W      = 5;
    localparam int CNT_W     = 8;
    localparam int HYST_W    = 8;
    localparam int CFG_W     = 11;
    localparam int CFG_IDX_W = 3;

    localparam logic [CFG_IDX_W-1:0] REG_HYST_BELOW   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_HYST_ABOVE   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_SENSOR_ONE   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_SENSOR_TWO   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_AVERAGE_CNT  = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_MANUAL_ON_MV = 3'd5;

    localparam int ADC_ZERO    = 12;
    localparam int ADC_FULL_MV = 1087;

    localparam logic [SUM_W-1:0] SUM_MAX = {SUM_W{1'b1}};

    localparam logic [5:0] CHAN_OFFSET [4] = '{6'd28, 6'd36, 6'd28, 6'd40};

    typedef struct packed {
        logic busy;
        logic done;
    } div_stat_t;

endpackage

[rtl/ahtu_in_if.sv]
interface ahtu_in_if #(
    parameter int ADC_WIDTH = 11
);
    logic                 valid;
    logic                 ready;
    logic                 action;
    logic                 control_enable;
    logic [ADC_WIDTH-1:0] pot_raw;
    logic [ADC_WIDTH-1:0] temp_one_raw;
    logic [ADC_WIDTH-1:0] hum_one_raw;
    logic [ADC_WIDTH-1:0] temp_two_raw;
    logic [ADC_WIDTH-1:0] hum_two_raw;

    modport source (
        output valid, action, control_enable, pot_raw,
        output temp_one_raw, hum_one_raw, temp_two_raw, hum_two_raw,
        input  ready
    );

    modport sink (
        input  valid, action, control_enable, pot_raw,
        input  temp_one_raw, hum_one_raw, temp_two_raw, hum_two_raw,
        output ready
    );
endinterface

[rtl/ahtu_out_if.sv]
interface ahtu_out_if;
    import ahtu_pkg::*;

    logic                    valid;
    logic                    ready;
    logic                    relay_on;
    logic [SP_W-1:0]         setpoint_deg;
    logic                    report_valid;
    logic signed [AVG_W-1:0] temp_one_avg;
    logic [AVG_W-1:0]        hum_one_avg;
    logic signed [AVG_W-1:0] temp_two_avg;
    logic [AVG_W-1:0]        hum_two_avg;
    logic                    no_sensor;

    modport source (
        output valid, relay_on, setpoint_deg, report_valid,
        output temp_one_avg, hum_one_avg, temp_two_avg, hum_two_avg, no_sensor,
        input  ready
    );

    modport sink (
        input  valid, relay_on, setpoint_deg, report_valid,
        input  temp_one_avg, hum_one_avg, temp_two_avg, hum_two_avg, no_sensor,
        output ready
    );
endinterface

[rtl/ahtu_divider.sv]
module ahtu_divider #(
    parameter int DIVIDEND_W = 23,
    parameter int DIVISOR_W  = 12
) (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    start,
    input  logic [DIVIDEND_W-1:0]   dividend,
    input  logic [DIVISOR_W-1:0]    divisor,
    output logic [DIVIDEND_W-1:0]   quotient,
    output ahtu_pkg::div_stat_t     stat
);
    import ahtu_pkg::*;

    localparam int STEP_W = $clog2(DIVIDEND_W + 1);

    logic [DIVISOR_W-1:0]  rem_reg;
    logic [DIVIDEND_W-1:0] q_reg;
    logic [DIVISOR_W-1:0]  den_reg;
    logic [STEP_W-1:0]     count_reg;
    logic                  busy_reg;
    logic                  done_reg;

    logic [DIVISOR_W:0]    shifted;
    logic [DIVISOR_W+1:0]  diff;
    logic                  borrow;

    always_comb
    begin
        shifted = {rem_reg, q_reg[DIVIDEND_W-1]};
        diff    = {1'b0, shifted} - {2'b00, den_reg};
        borrow  = diff[DIVISOR_W+1];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg  <= 1'b0;
            done_reg  <= 1'b0;
            count_reg <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg  <= 1'b1;
                count_reg <= STEP_W'(DIVIDEND_W);
            end
            else if (busy_reg)
            begin
                count_reg <= count_reg - 1'b1;
                if (count_reg == STEP_W'(1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rem_reg <= '0;
            q_reg   <= dividend;
            den_reg <= divisor;
        end
        else if (busy_reg)
        begin
            if (borrow)
            begin
                rem_reg <= shifted[DIVISOR_W-1:0];
            end
            else
            begin
                rem_reg <= diff[DIVISOR_W-1:0];
            end
            q_reg <= {q_reg[DIVIDEND_W-2:0], ~borrow};
        end
    end

    assign quotient  = q_reg;
    assign stat.busy = busy_reg;
    assign stat.done = done_reg;

endmodule

[rtl/averaging_hysteresis_thermostat_unit.sv]
// Channel    Direction  Handshake            Contents
// reading    in         valid/ready          action, enable, five raw ADC values
// status     out        valid/ready          relay, setpoint, report and averages
// cfg        in         cfg_we, no back-off  register index and data
//
// Each millivolt value passes through a constant reciprocal product, and every average is
// computed on one shared restoring divider.
// A new item is accepted only in the idle state, once the last item has finished, including
// the averages of a reporting sensor item and the relay control when it runs.
// Reset clears all control state, the sums and the count; no clearing pass is run.
// The next item is accepted while a finished result still waits in the output stage.
module averaging_hysteresis_thermostat_unit #(
    parameter int ADC_WIDTH = 11
) (
    input  logic                            clk,
    input  logic                            rst_n,
    ahtu_in_if.sink                         reading,
    ahtu_out_if.source                      status,
    input  logic                            cfg_we,
    input  logic [ahtu_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [ahtu_pkg::CFG_W-1:0]      cfg_data
);
    import ahtu_pkg::*;

    localparam int ADC_MAX  = (1 << ADC_WIDTH) - 1;
    localparam int MV_DEN   = ADC_MAX - ADC_ZERO;
    localparam int DIV_W    = SUM_W + 4;
    localparam int DEN_W    = CNT_W + 4;

    localparam int          RECIP_SH = 2 * ADC_WIDTH + 11;
    localparam logic [63:0] RECIP    = ((64'd1 << RECIP_SH) + 64'(MV_DEN) - 64'd1)
                                       / 64'(MV_DEN);
    localparam logic [63:0] MV_MULT  = RECIP * 64'(ADC_FULL_MV);
    localparam int          MVP_W    = 2 * ADC_WIDTH + 23;

    localparam int SP_BASE    = 22;
    localparam int SP_STEP_MV = 1000 / 4;
    localparam int SP_STEPS   = (ADC_FULL_MV + SP_STEP_MV - 1) / SP_STEP_MV;

    localparam logic [3:0] S_IDLE      = 4'd0;
    localparam logic [3:0] S_MV_START  = 4'd1;
    localparam logic [3:0] S_MV_WAIT   = 4'd2;
    localparam logic [3:0] S_COUNT     = 4'd4;
    localparam logic [3:0] S_AVG_START = 4'd5;
    localparam logic [3:0] S_AVG_WAIT  = 4'd6;
    localparam logic [3:0] S_HYST_PREP = 4'd7;
    localparam logic [3:0] S_HYST_LO   = 4'd8;
    localparam logic [3:0] S_HYST_HI   = 4'd9;
    localparam logic [3:0] S_FINISH    = 4'd10;

    logic [HYST_W-1:0] hyst_below_reg;
    logic [HYST_W-1:0] hyst_above_reg;
    logic              sensor_one_reg;
    logic              sensor_two_reg;
    logic [CNT_W-1:0]  average_count_reg;
    logic [MV_W-1:0]   manual_on_reg;

    logic [3:0]           state_reg, state_next;
    logic [1:0]           idx_reg, idx_next;
    logic                 action_reg;
    logic                 enable_reg;
    logic [ADC_WIDTH-1:0] pot_raw_reg;
    logic [ADC_WIDTH-1:0] sens_raw_reg [4];
    logic [SUM_W-1:0]     sums_reg [4];
    logic [SUM_W-1:0]     sums_next [4];
    logic [CNT_W-1:0]     sample_count_reg, sample_count_next;
    logic [CNT_W-1:0]     n_reg, n_next;
    logic [SP_W-1:0]      setpoint_reg, setpoint_next;
    logic                 relay_reg, relay_next;
    logic                 report_reg, report_next;
    logic                 none_reg, none_next;
    logic [AVG_W-1:0]     avg_reg [4];
    logic [AVG_W-1:0]     avg_next [4];
    logic [22:0]          lhs_reg, lhs_next;
    logic signed [12:0]   lo_term_reg, lo_term_next;
    logic signed [12:0]   hi_term_reg, hi_term_next;
    logic [11:0]          scale_reg, scale_next;
    logic [MV_W-1:0]      mv_reg, mv_next;

    logic                 out_valid_reg;
    logic                 out_relay_reg;
    logic [SP_W-1:0]      out_setpoint_reg;
    logic                 out_report_reg;
    logic [AVG_W-1:0]     out_avg_reg [4];
    logic                 out_none_reg;
    logic                 out_load;

    logic                 in_take;
    logic [ADC_WIDTH-1:0] raw_sel;
    logic                 raw_low;
    logic [MVP_W-1:0]     mv_prod;
    logic                 mv_event;
    logic [MV_W-1:0]      mv_val;
    logic [2:0]           sp_steps;
    logic [SP_W-1:0]      sp_calc;
    logic [19:0]          sum_add;
    logic [CNT_W:0]       n_calc;
    logic [CNT_W-1:0]     n_cfg;
    logic [22:0]          temp_dividend;
    logic [SUM_W-1:0]     sel_sum;
    logic signed [12:0]   term_sel;
    logic signed [25:0]   hyst_prod;
    logic signed [25:0]   lhs_ext;

    logic                 div_start;
    logic [DIV_W-1:0]     div_dividend;
    logic [DEN_W-1:0]     div_divisor;
    logic [DIV_W-1:0]     div_quotient;
    div_stat_t            div_stat;

    ahtu_divider #(
        .DIVIDEND_W (DIV_W),
        .DIVISOR_W  (DEN_W)
    ) u_divider (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (div_dividend),
        .divisor  (div_divisor),
        .quotient (div_quotient),
        .stat     (div_stat)
    );

    assign reading.ready = (state_reg == S_IDLE);
    assign in_take       = reading.valid && reading.ready;

    always_comb
    begin
        raw_sel       = action_reg ? sens_raw_reg[idx_reg] : pot_raw_reg;
        raw_low       = (raw_sel <= ADC_WIDTH'(ADC_ZERO));
        mv_prod       = MVP_W'(raw_sel - ADC_WIDTH'(ADC_ZERO)) * MVP_W'(MV_MULT);
        mv_event      = (state_reg == S_MV_WAIT);
        mv_val        = mv_reg;
        sp_steps      = '0;
        for (int k = 0; k < SP_STEPS; k++)
        begin
            if (mv_val > MV_W'(k * SP_STEP_MV))
            begin
                sp_steps = sp_steps + 1'b1;
            end
        end
        sp_calc       = SP_W'(SP_BASE) - SP_W'(sp_steps);
        sum_add       = {1'b0, sums_reg[idx_reg]} + 20'(mv_val)
                        + 20'(CHAN_OFFSET[idx_reg]);
        n_calc        = {1'b0, sample_count_reg} + 1'b1;
        n_cfg         = (average_count_reg == '0) ? CNT_W'(1) : average_count_reg;
        temp_dividend = 23'(sums_reg[idx_reg]) * 23'd12;
        sel_sum       = sensor_one_reg ? sums_reg[0] : sums_reg[2];
        term_sel      = (state_reg == S_HYST_LO) ? lo_term_reg : hi_term_reg;
        hyst_prod     = 26'(term_sel) * $signed({14'd0, scale_reg});
        lhs_ext       = $signed({3'b000, lhs_reg});
    end

    always_comb
    begin
        if (!idx_reg[0])
        begin
            div_dividend = DIV_W'(temp_dividend);
            div_divisor  = DEN_W'(n_reg) * DEN_W'(10);
        end
        else
        begin
            div_dividend = DIV_W'(sums_reg[idx_reg]);
            div_divisor  = DEN_W'(n_reg);
        end
    end

    always_comb
    begin
        state_next        = state_reg;
        idx_next          = idx_reg;
        sums_next         = sums_reg;
        sample_count_next = sample_count_reg;
        n_next            = n_reg;
        setpoint_next     = setpoint_reg;
        relay_next        = relay_reg;
        report_next       = report_reg;
        none_next         = none_reg;
        avg_next          = avg_reg;
        lhs_next          = lhs_reg;
        lo_term_next      = lo_term_reg;
        hi_term_next      = hi_term_reg;
        scale_next        = scale_reg;
        mv_next           = mv_reg;
        div_start         = 1'b0;
        out_load          = 1'b0;

        unique case (state_reg)
            S_IDLE:
            begin
                if (in_take)
                begin
                    state_next  = S_MV_START;
                    idx_next    = '0;
                    report_next = 1'b0;
                    none_next   = 1'b0;
                    for (int i = 0; i < 4; i++)
                    begin
                        avg_next[i] = '0;
                    end
                end
            end
            S_MV_START:
            begin
                mv_next    = raw_low ? '0 : mv_prod[RECIP_SH +: MV_W];
                state_next = S_MV_WAIT;
            end
            S_MV_WAIT:
            begin
            end
            S_COUNT:
            begin
                if (n_calc >= {1'b0, n_cfg})
                begin
                    report_next = 1'b1;
                    n_next      = n_calc[CNT_W-1:0];
                    none_next   = !sensor_one_reg && !sensor_two_reg;
                    idx_next    = '0;
                    state_next  = S_AVG_START;
                end
                else
                begin
                    sample_count_next = n_calc[CNT_W-1:0];
                    state_next        = S_FINISH;
                end
            end
            S_AVG_START:
            begin
                div_start  = 1'b1;
                state_next = S_AVG_WAIT;
            end
            S_AVG_WAIT:
            begin
                if (div_stat.done)
                begin
                    if (!idx_reg[0])
                    begin
                        if (div_quotient > DIV_W'(1400))
                        begin
                            avg_next[idx_reg] = AVG_W'(1000);
                        end
                        else
                        begin
                            avg_next[idx_reg] = div_quotient[AVG_W-1:0] - AVG_W'(400);
                        end
                    end
                    else
                    begin
                        if (div_quotient > DIV_W'(1200))
                        begin
                            avg_next[idx_reg] = AVG_W'(1200);
                        end
                        else
                        begin
                            avg_next[idx_reg] = div_quotient[AVG_W-1:0];
                        end
                    end
                    if (idx_reg == 2'd3)
                    begin
                        idx_next   = '0;
                        state_next = (enable_reg && !none_reg) ? S_HYST_PREP : S_FINISH;
                    end
                    else
                    begin
                        idx_next   = idx_reg + 1'b1;
                        state_next = S_AVG_START;
                    end
                end
            end
            S_HYST_PREP:
            begin
                lhs_next     = 23'(sel_sum) * 23'd12;
                lo_term_next = ($signed({8'd0, setpoint_reg})
                                - $signed({5'd0, hyst_below_reg})) * 13'sd10 + 13'sd400;
                hi_term_next = ($signed({8'd0, setpoint_reg})
                                + $signed({5'd0, hyst_above_reg})) * 13'sd10 + 13'sd400;
                scale_next   = 12'(n_reg) * 12'd10;
                state_next   = S_HYST_LO;
            end
            S_HYST_LO:
            begin
                if (lhs_ext < hyst_prod)
                begin
                    relay_next = 1'b1;
                    state_next = S_FINISH;
                end
                else
                begin
                    state_next = S_HYST_HI;
                end
            end
            S_HYST_HI:
            begin
                if (lhs_ext > hyst_prod)
                begin
                    relay_next = 1'b0;
                end
                state_next = S_FINISH;
            end
            S_FINISH:
            begin
                if (!out_valid_reg || status.ready)
                begin
                    out_load   = 1'b1;
                    state_next = S_IDLE;
                    if (report_reg)
                    begin
                        sample_count_next = '0;
                        for (int i = 0; i < 4; i++)
                        begin
                            sums_next[i] = '0;
                        end
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        if (mv_event)
        begin
            if (!action_reg)
            begin
                if (enable_reg)
                begin
                    setpoint_next = sp_calc;
                end
                else
                begin
                    relay_next = (mv_val < manual_on_reg);
                end
                state_next = S_FINISH;
            end
            else
            begin
                sums_next[idx_reg] = (sum_add > 20'(SUM_MAX)) ? SUM_MAX
                                                              : sum_add[SUM_W-1:0];
                if (idx_reg == 2'd3)
                begin
                    idx_next   = '0;
                    state_next = S_COUNT;
                end
                else
                begin
                    idx_next   = idx_reg + 1'b1;
                    state_next = S_MV_START;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hyst_below_reg    <= HYST_W'(1);
            hyst_above_reg    <= HYST_W'(1);
            sensor_one_reg    <= 1'b0;
            sensor_two_reg    <= 1'b0;
            average_count_reg <= CNT_W'(50);
            manual_on_reg     <= MV_W'(1);
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_HYST_BELOW:   hyst_below_reg    <= cfg_data[HYST_W-1:0];
                REG_HYST_ABOVE:   hyst_above_reg    <= cfg_data[HYST_W-1:0];
                REG_SENSOR_ONE:   sensor_one_reg    <= cfg_data[0];
                REG_SENSOR_TWO:   sensor_two_reg    <= cfg_data[0];
                REG_AVERAGE_CNT:  average_count_reg <= cfg_data[CNT_W-1:0];
                REG_MANUAL_ON_MV: manual_on_reg     <= cfg_data[MV_W-1:0];
                default:
                begin
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= S_IDLE;
            idx_reg          <= '0;
            sample_count_reg <= '0;
            setpoint_reg     <= SP_W'(30);
            relay_reg        <= 1'b0;
            report_reg       <= 1'b0;
            none_reg         <= 1'b0;
            out_valid_reg    <= 1'b0;
            for (int i = 0; i < 4; i++)
            begin
                sums_reg[i] <= '0;
            end
        end
        else
        begin
            state_reg        <= state_next;
            idx_reg          <= idx_next;
            sample_count_reg <= sample_count_next;
            setpoint_reg     <= setpoint_next;
            relay_reg        <= relay_next;
            report_reg       <= report_next;
            none_reg         <= none_next;
            sums_reg         <= sums_next;
            if (out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (status.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            action_reg      <= reading.action;
            enable_reg      <= reading.control_enable;
            pot_raw_reg     <= reading.pot_raw;
            sens_raw_reg[0] <= reading.temp_one_raw;
            sens_raw_reg[1] <= reading.hum_one_raw;
            sens_raw_reg[2] <= reading.temp_two_raw;
            sens_raw_reg[3] <= reading.hum_two_raw;
        end
        n_reg       <= n_next;
        avg_reg     <= avg_next;
        lhs_reg     <= lhs_next;
        lo_term_reg <= lo_term_next;
        hi_term_reg <= hi_term_next;
        scale_reg   <= scale_next;
        mv_reg      <= mv_next;
        if (out_load)
        begin
            out_relay_reg    <= relay_reg;
            out_setpoint_reg <= setpoint_reg;
            out_report_reg   <= report_reg;
            out_avg_reg      <= avg_reg;
            out_none_reg     <= none_reg;
        end
    end

    assign status.valid        = out_valid_reg;
    assign status.relay_on     = out_relay_reg;
    assign status.setpoint_deg = out_setpoint_reg;
    assign status.report_valid = out_report_reg;
    assign status.temp_one_avg = $signed(out_avg_reg[0]);
    assign status.hum_one_avg  = out_avg_reg[1];
    assign status.temp_two_avg = $signed(out_avg_reg[2]);
    assign status.hum_two_avg  = out_avg_reg[3];
    assign status.no_sensor    = out_none_reg;

    a_no_accept_while_dividing: assert property (
        @(posedge clk) disable iff (!rst_n)
        div_stat.busy |-> !reading.ready
    ) else $error("Item accepted while the divider is busy.");

    a_done_in_wait_state: assert property (
        @(posedge clk) disable iff (!rst_n)
        div_stat.done |-> (state_reg == S_AVG_WAIT)
    ) else $error("Divider finished outside a waiting state.");

    a_count_below_max: assert property (
        @(posedge clk) disable iff (!rst_n)
        sample_count_reg != {CNT_W{1'b1}}
    ) else $error("Sample count reached its maximum without a report.");

    a_result_loaded_once: assert property (
        @(posedge clk) disable iff (!rst_n)
        out_load |=> (state_reg == S_IDLE && out_valid_reg)
    ) else $error("Result stage not loaded on finishing an item.");

endmodule

[bench/tb_top.sv]
`timescale 1ns / 1ps

module tb_top;
    import ahtu_pkg::*;

    localparam int ADC_W   = 11;
    localparam int ADC_TOP = (1 << ADC_W) - 1;
    localparam int TAIL_CYCLES = 400;

    localparam logic ACT_POT    = 1'b0;
    localparam logic ACT_SENSOR = 1'b1;

    typedef struct {
        logic             action;
        logic             control_enable;
        logic [ADC_W-1:0] pot_raw;
        logic [ADC_W-1:0] temp_one_raw;
        logic [ADC_W-1:0] hum_one_raw;
        logic [ADC_W-1:0] temp_two_raw;
        logic [ADC_W-1:0] hum_two_raw;
    } reading_t;

    typedef struct {
        logic                    relay_on;
        logic [SP_W-1:0]         setpoint_deg;
        logic                    report_valid;
        logic signed [AVG_W-1:0] temp_one_avg;
        logic [AVG_W-1:0]        hum_one_avg;
        logic signed [AVG_W-1:0] temp_two_avg;
        logic [AVG_W-1:0]        hum_two_avg;
        logic                    no_sensor;
    } status_t;

    logic                 clk;
    logic                 rst_n;
    logic                 cfg_we;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [CFG_W-1:0]     cfg_data;

    ahtu_in_if #(.ADC_WIDTH(ADC_W)) rd_if ();
    ahtu_out_if                     st_if ();

    averaging_hysteresis_thermostat_unit #(
        .ADC_WIDTH(ADC_W)
    ) i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .reading   (rd_if),
        .status    (st_if),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    reading_t readings_todo [$];
    status_t  status_due [$];

    int unsigned cfg_hyst_below;
    int unsigned cfg_hyst_above;
    int unsigned cfg_sensor_one;
    int unsigned cfg_sensor_two;
    int unsigned cfg_avg_count;
    int unsigned cfg_manual_mv;

    logic [CNT_W-1:0] held_samples;
    logic [SUM_W-1:0] mv_sum [4];
    logic [SP_W-1:0]  setpoint_now;
    logic             relay_now;

    int   send_idle_pct;
    int   recv_stall_pct;
    logic long_hold;
    logic took_item;
    int   mismatches;
    event hold_go;

    always #6 clk = ~clk;

    function automatic int unsigned raw_millivolts(logic [ADC_W-1:0] raw);
        if (raw <= ADC_ZERO)
        begin
            return 0;
        end
        return ((int'(raw) - ADC_ZERO) * ADC_FULL_MV) / (ADC_TOP - ADC_ZERO);
    endfunction

    function automatic logic signed [AVG_W-1:0] temp_tenths(longint sum, longint n);
        longint t;
        t = (sum * 12) / (n * 10) - 400;
        if (t > 1000)
        begin
            t = 1000;
        end
        if (t < -400)
        begin
            t = -400;
        end
        return t[AVG_W-1:0];
    endfunction

    function automatic logic [AVG_W-1:0] hum_tenths(longint sum, longint n);
        longint h;
        h = sum / n;
        if (h > 1200)
        begin
            h = 1200;
        end
        return h[AVG_W-1:0];
    endfunction

    function automatic status_t next_status(reading_t r);
        status_t          s;
        int unsigned      mv;
        int unsigned      n_cfg;
        int unsigned      n;
        longint           tot;
        longint           t;
        longint           lhs;
        longint           lo;
        longint           hi;
        longint           scale;
        logic [ADC_W-1:0] raws [4];
        s.relay_on     = 1'b0;
        s.setpoint_deg = '0;
        s.report_valid = 1'b0;
        s.temp_one_avg = '0;
        s.hum_one_avg  = '0;
        s.temp_two_avg = '0;
        s.hum_two_avg  = '0;
        s.no_sensor    = 1'b0;
        if (r.action == ACT_POT)
        begin
            mv = raw_millivolts(r.pot_raw);
            if (r.control_enable)
            begin
                t = 22000 - 4 * longint'(mv);
                setpoint_now = (t <= 0) ? '0 : SP_W'(t / 1000);
            end
            else
            begin
                relay_now = (mv < cfg_manual_mv);
            end
        end
        else
        begin
            raws[0] = r.temp_one_raw;
            raws[1] = r.hum_one_raw;
            raws[2] = r.temp_two_raw;
            raws[3] = r.hum_two_raw;
            n_cfg = (cfg_avg_count == 0) ? 1 : cfg_avg_count;
            for (int i = 0; i < 4; i++)
            begin
                tot = longint'(mv_sum[i]) + raw_millivolts(raws[i]) + CHAN_OFFSET[i];
                mv_sum[i] = (tot > SUM_MAX) ? SUM_MAX : tot[SUM_W-1:0];
            end
            n = held_samples + 1;
            if (n >= n_cfg)
            begin
                s.report_valid = 1'b1;
                s.temp_one_avg = temp_tenths(mv_sum[0], n);
                s.hum_one_avg  = hum_tenths(mv_sum[1], n);
                s.temp_two_avg = temp_tenths(mv_sum[2], n);
                s.hum_two_avg  = hum_tenths(mv_sum[3], n);
                s.no_sensor    = (cfg_sensor_one == 0) && (cfg_sensor_two == 0);
                if (r.control_enable && !s.no_sensor)
                begin
                    lhs   = 12 * longint'((cfg_sensor_one != 0) ? mv_sum[0] : mv_sum[2]);
                    lo    = longint'(setpoint_now) - longint'(cfg_hyst_below);
                    hi    = longint'(setpoint_now) + longint'(cfg_hyst_above);
                    scale = 10 * longint'(n);
                    if (lhs < (lo * 10 + 400) * scale)
                    begin
                        relay_now = 1'b1;
                    end
                    else if (lhs > (hi * 10 + 400) * scale)
                    begin
                        relay_now = 1'b0;
                    end
                end
                for (int i = 0; i < 4; i++)
                begin
                    mv_sum[i] = '0;
                end
                held_samples = '0;
            end
            else
            begin
                held_samples = n[CNT_W-1:0];
            end
        end
        s.relay_on     = relay_now;
        s.setpoint_deg = setpoint_now;
        return s;
    endfunction

    task automatic note_mismatch(string msg);
        $display("[%0t] status item: %s", $time, msg);
        mismatches++;
    endtask

    task automatic check_field(string name, logic signed [31:0] got, logic signed [31:0] want);
        if (got !== want)
        begin
            note_mismatch($sformatf("%s is %0d, %0d predicted", name, got, want));
        end
    endtask

    always @(posedge clk)
    begin
        status_t  want;
        reading_t seen;
        took_item <= rd_if.valid && rd_if.ready;
        if (rst_n)
        begin
            if (st_if.valid && st_if.ready)
            begin
                if (status_due.size() == 0)
                begin
                    note_mismatch("arrived with nothing predicted");
                end
                else
                begin
                    want = status_due.pop_front();
                    check_field("relay_on", st_if.relay_on, want.relay_on);
                    check_field("setpoint_deg", st_if.setpoint_deg, want.setpoint_deg);
                    check_field("report_valid", st_if.report_valid, want.report_valid);
                    check_field("temp_one_avg", st_if.temp_one_avg, want.temp_one_avg);
                    check_field("hum_one_avg", st_if.hum_one_avg, want.hum_one_avg);
                    check_field("temp_two_avg", st_if.temp_two_avg, want.temp_two_avg);
                    check_field("hum_two_avg", st_if.hum_two_avg, want.hum_two_avg);
                    check_field("no_sensor", st_if.no_sensor, want.no_sensor);
                end
            end
            if (rd_if.valid && rd_if.ready)
            begin
                seen.action         = rd_if.action;
                seen.control_enable = rd_if.control_enable;
                seen.pot_raw        = rd_if.pot_raw;
                seen.temp_one_raw   = rd_if.temp_one_raw;
                seen.hum_one_raw    = rd_if.hum_one_raw;
                seen.temp_two_raw   = rd_if.temp_two_raw;
                seen.hum_two_raw    = rd_if.hum_two_raw;
                status_due.push_back(next_status(seen));
            end
        end
    end

    always @(negedge clk)
    begin
        reading_t nxt;
        if (!rd_if.valid || took_item)
        begin
            if (readings_todo.size() != 0 && $urandom_range(99) >= send_idle_pct)
            begin
                nxt = readings_todo.pop_front();
                rd_if.valid          <= 1'b1;
                rd_if.action         <= nxt.action;
                rd_if.control_enable <= nxt.control_enable;
                rd_if.pot_raw        <= nxt.pot_raw;
                rd_if.temp_one_raw   <= nxt.temp_one_raw;
                rd_if.hum_one_raw    <= nxt.hum_one_raw;
                rd_if.temp_two_raw   <= nxt.temp_two_raw;
                rd_if.hum_two_raw    <= nxt.hum_two_raw;
            end
            else
            begin
                rd_if.valid <= 1'b0;
            end
        end
    end

    always @(negedge clk)
    begin
        st_if.ready <= !long_hold && ($urandom_range(99) >= recv_stall_pct);
    end

    initial
    begin
        forever
        begin
            @(hold_go);
            @(posedge clk);
            long_hold = 1'b1;
            repeat (2000) @(posedge clk);
            long_hold = 1'b0;
        end
    end

    task automatic push_reading(logic act, logic en, int pot, int t1, int h1, int t2, int h2);
        reading_t r;
        r.action         = act;
        r.control_enable = en;
        r.pot_raw        = pot[ADC_W-1:0];
        r.temp_one_raw   = t1[ADC_W-1:0];
        r.hum_one_raw    = h1[ADC_W-1:0];
        r.temp_two_raw   = t2[ADC_W-1:0];
        r.hum_two_raw    = h2[ADC_W-1:0];
        readings_todo.push_back(r);
    endtask

    function automatic int band_raw();
        if ($urandom_range(99) < 65)
        begin
            return $urandom_range(1100, 700);
        end
        return $urandom_range(ADC_TOP, 0);
    endfunction

    function automatic int pot_pick();
        case ($urandom_range(9))
            0: return $urandom_range(14, 0);
            1: return $urandom_range(ADC_TOP, ADC_TOP - 7);
            default: return $urandom_range(ADC_TOP, 0);
        endcase
    endfunction

    task automatic push_random_reading();
        logic act;
        logic en;
        act = ($urandom_range(99) < 20) ? ACT_POT : ACT_SENSOR;
        en  = ($urandom_range(99) < 85);
        push_reading(act, en, pot_pick(), band_raw(), $urandom_range(ADC_TOP, 0),
                     band_raw(), $urandom_range(ADC_TOP, 0));
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, int unsigned value);
        @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value[CFG_W-1:0];
    endtask

    task automatic apply_config(int unsigned hb, int unsigned ha, int unsigned s1,
                                int unsigned s2, int unsigned avg, int unsigned mon);
        write_reg(REG_HYST_BELOW, hb);
        write_reg(REG_HYST_ABOVE, ha);
        write_reg(REG_SENSOR_ONE, s1);
        write_reg(REG_SENSOR_TWO, s2);
        write_reg(REG_AVERAGE_CNT, avg);
        write_reg(REG_MANUAL_ON_MV, mon);
        @(negedge clk);
        cfg_we <= 1'b0;
        cfg_hyst_below = hb & 8'hFF;
        cfg_hyst_above = ha & 8'hFF;
        cfg_sensor_one = s1 & 1;
        cfg_sensor_two = s2 & 1;
        cfg_avg_count  = avg & 8'hFF;
        cfg_manual_mv  = mon & 11'h7FF;
        @(posedge clk);
    endtask

    task automatic wait_quiet();
        while (readings_todo.size() != 0 || rd_if.valid || status_due.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (4) @(posedge clk);
    endtask

    task automatic run_phase(int send_pct, int recv_pct, int items, logic hold,
                             int unsigned hb, int unsigned ha, int unsigned s1,
                             int unsigned s2, int unsigned avg, int unsigned mon);
        apply_config(hb, ha, s1, s2, avg, mon);
        send_idle_pct  = send_pct;
        recv_stall_pct = recv_pct;
        for (int i = 0; i < items; i++)
        begin
            push_random_reading();
        end
        if (hold)
        begin
            -> hold_go;
        end
        wait_quiet();
    endtask

    initial
    begin
        clk                  = 1'b0;
        rst_n                = 1'b0;
        cfg_we               = 1'b0;
        cfg_index            = '0;
        cfg_data             = '0;
        rd_if.valid          = 1'b0;
        rd_if.action         = 1'b0;
        rd_if.control_enable = 1'b0;
        rd_if.pot_raw        = '0;
        rd_if.temp_one_raw   = '0;
        rd_if.hum_one_raw    = '0;
        rd_if.temp_two_raw   = '0;
        rd_if.hum_two_raw    = '0;
        st_if.ready          = 1'b0;
        took_item            = 1'b0;
        long_hold            = 1'b0;
        send_idle_pct        = 0;
        recv_stall_pct       = 0;
        mismatches           = 0;
        cfg_hyst_below       = 1;
        cfg_hyst_above       = 1;
        cfg_sensor_one       = 0;
        cfg_sensor_two       = 0;
        cfg_avg_count        = 50;
        cfg_manual_mv        = 1;
        held_samples         = '0;
        setpoint_now         = SP_W'(30);
        relay_now            = 1'b0;
        for (int i = 0; i < 4; i++)
        begin
            mv_sum[i] = '0;
        end

        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(posedge clk);

        push_reading(ACT_POT, 1'b1, 0, 0, 0, 0, 0);
        push_reading(ACT_POT, 1'b1, 12, 0, 0, 0, 0);
        push_reading(ACT_POT, 1'b1, 13, 0, 0, 0, 0);
        push_reading(ACT_POT, 1'b1, ADC_TOP, 0, 0, 0, 0);
        push_reading(ACT_POT, 1'b0, 0, 0, 0, 0, 0);
        push_reading(ACT_POT, 1'b0, ADC_TOP, 0, 0, 0, 0);
        push_reading(ACT_POT, 1'b0, 13, 0, 0, 0, 0);
        push_reading(ACT_SENSOR, 1'b1, 0, 0, 0, 0, 0);
        push_reading(ACT_SENSOR, 1'b1, ADC_TOP, ADC_TOP, ADC_TOP, ADC_TOP, ADC_TOP);
        wait_quiet();

        apply_config(0, 0, 1, 0, 1, 1200);
        push_reading(ACT_SENSOR, 1'b1, 0, ADC_TOP, ADC_TOP, ADC_TOP, ADC_TOP);
        push_reading(ACT_SENSOR, 1'b1, ADC_TOP, 0, 0, 0, 0);
        push_reading(ACT_SENSOR, 1'b0, 'h555, 'h555, 'h2AA, 'h555, 'h2AA);
        push_reading(ACT_SENSOR, 1'b0, 'h2AA, 'h2AA, 'h555, 'h2AA, 'h555);
        push_reading(ACT_POT, 1'b0, ADC_TOP, 0, 0, 0, 0);
        push_reading(ACT_SENSOR, 1'b1, 0, 880, 600, 880, 600);
        wait_quiet();

        apply_config(255, 255, 0, 1, 0, 0);
        push_reading(ACT_SENSOR, 1'b1, 0, ADC_TOP, 100, 0, 100);
        push_reading(ACT_SENSOR, 1'b1, 0, 0, 100, ADC_TOP, 100);
        wait_quiet();

        apply_config(1, 1, 0, 0, 1, 600);
        push_reading(ACT_SENSOR, 1'b1, 0, 0, 0, 0, 0);
        wait_quiet();

        run_phase(0, 0, 135, 1'b0, 1, 1, 1, 0, 4, 600);
        run_phase(71, 0, 135, 1'b0, 0, 0, 1, 1, 1, 0);
        run_phase(0, 71, 135, 1'b1, 255, 255, 0, 1, 8, 1200);
        run_phase(33, 33, 135, 1'b0, 2, 0, 0, 0, 3, 500);
        run_phase(0, 0, 135, 1'b0, 0, 3, 1, 0, 255, 1087);
        run_phase(33, 33, 135, 1'b0, $urandom_range(3), $urandom_range(3), 1, 1, 5,
                  $urandom_range(1200));

        repeat (TAIL_CYCLES) @(posedge clk);
        if (mismatches == 0)
        begin
            $display("SCOREBOARD CLEAN");
        end
        else
        begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

    initial
    begin
        #60_000_000;
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule

[files.f]
rtl/ahtu_pkg.sv
rtl/ahtu_in_if.sv
rtl/ahtu_out_if.sv
rtl/ahtu_divider.sv
rtl/averaging_hysteresis_thermostat_unit.sv
bench/tb_top.sv
